@@ design/psca_pkg.sv @@
// ----------------------------------------------------------------------------
// psca_pkg
// Shared widths, register indexes, reset values and types of the pulse
// shaping charge analyser.
// ----------------------------------------------------------------------------
`default_nettype none

package psca_pkg;

    localparam int MAX_SAMPLES = 4096;
    localparam int ADDR_W      = $clog2(MAX_SAMPLES);
    localparam int CNT_W       = ADDR_W + 1;
    localparam int SMP_W       = 16;
    localparam int Q_W         = 40;
    localparam int CHG_W       = 51;
    localparam int COEF_W      = 16;
    localparam int GATE_W      = 11;
    localparam int WIN_W       = 10;
    localparam int SUM_W       = 27;
    localparam int DIV_W       = 42;
    localparam int BASE_W      = 33;
    localparam int LP_STAGES   = 4;
    localparam int LP_W        = $clog2(LP_STAGES);
    localparam int DCNT_W      = $clog2(DIV_W);
    localparam int GATE_MAX    = 1024;
    localparam int CFG_IDX_W   = 3;

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] REG_SHAPING_EN    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LOWPASS_COEF  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HIGHPASS_COEF = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BASELINE_GATE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_HALF   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_QLIM   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_POLARITY_AUTO = 3'd6;

    typedef struct packed {
        logic              shaping_en;
        logic [COEF_W-1:0] lowpass_coef;
        logic [COEF_W-1:0] highpass_coef;
        logic [GATE_W-1:0] baseline_gate;
        logic [WIN_W-1:0]  window_half;
        logic              window_quarter_limit;
        logic              polarity_auto;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{
        shaping_en:           1'b1,
        lowpass_coef:         16'd434,
        highpass_coef:        16'd65102,
        baseline_gate:        11'd100,
        window_half:          10'd50,
        window_quarter_limit: 1'b0,
        polarity_auto:        1'b0
    };

    // One loaded waveform, handed from the loader to the evaluator.
    typedef struct packed {
        logic [CNT_W-1:0]        n;
        logic                    ovf;
        logic signed [SUM_W-1:0] sum;
        logic [GATE_W-1:0]       gate;
    } t_job;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIV,
        ST_RD,
        ST_LOAD,
        ST_HP,
        ST_LP,
        ST_WR,
        ST_PEAK,
        ST_WIN,
        ST_IRD,
        ST_IACC,
        ST_FIN
    } t_state;

endpackage

`default_nettype wire

@@ design/psca_front.sv @@
// ----------------------------------------------------------------------------
// psca_front
// Waveform loader: stores samples in the raw store, counts them, sums the
// baseline gate and queues one job per waveform for the evaluator.
// ----------------------------------------------------------------------------
`default_nettype none

module psca_front (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_in_valid,
    output logic                             o_in_ready,
    input  wire  signed [psca_pkg::SMP_W-1:0] i_sample,
    input  wire                              i_last,
    input  wire  [psca_pkg::GATE_W-1:0]      i_gate,
    input  wire  [psca_pkg::ADDR_W-1:0]      i_rd_addr,
    output logic signed [psca_pkg::SMP_W-1:0] o_rd_data,
    input  wire                              i_release,
    output logic                             o_job_valid,
    input  wire                              i_job_pop,
    output psca_pkg::t_job                   o_job
);
    import psca_pkg::*;

    logic signed [SMP_W-1:0] r_mem [MAX_SAMPLES];
    logic [CNT_W-1:0]        r_cnt, n_cnt;
    logic signed [SUM_W-1:0] r_sum, n_sum;
    logic                    r_wait;
    logic                    r_q_valid;
    t_job                    r_q;
    logic [GATE_W-1:0]       gate_c;
    logic [CNT_W-1:0]        n_len;
    logic                    accept;
    logic                    store;

    assign o_in_ready  = ~r_wait;
    assign accept      = i_in_valid & ~r_wait;
    assign store       = r_cnt < CNT_W'(MAX_SAMPLES);
    assign o_job_valid = r_q_valid;
    assign o_job       = r_q;

    // Clamp the gate to one at least and the gate limit at most.
    always_comb begin
        gate_c = i_gate;
        if (i_gate == '0) begin
            gate_c = GATE_W'(1);
        end else if (i_gate > GATE_W'(GATE_MAX)) begin
            gate_c = GATE_W'(GATE_MAX);
        end
    end

    // Count and baseline sum after this beat.
    always_comb begin
        n_cnt = r_cnt;
        n_sum = r_sum;
        if (store) begin
            n_cnt = r_cnt + CNT_W'(1);
            if (r_cnt < CNT_W'(gate_c)) begin
                n_sum = r_sum + SUM_W'(i_sample);
            end
        end else begin
            n_cnt = CNT_W'(MAX_SAMPLES + 1);
        end
        n_len = (n_cnt > CNT_W'(MAX_SAMPLES)) ? CNT_W'(MAX_SAMPLES) : n_cnt;
    end

    // Raw store write port.
    always_ff @(posedge i_clk) begin
        if (accept && store) begin
            r_mem[r_cnt[ADDR_W-1:0]] <= i_sample;
        end
    end

    // Raw store read port, registered.
    always_ff @(posedge i_clk) begin
        o_rd_data <= r_mem[i_rd_addr];
    end

    // Load control and one-entry job queue.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt     <= '0;
            r_sum     <= '0;
            r_wait    <= 1'b0;
            r_q_valid <= 1'b0;
        end else begin
            if (i_job_pop) begin
                r_q_valid <= 1'b0;
            end
            if (i_release) begin
                r_wait <= 1'b0;
            end
            if (accept) begin
                if (i_last) begin
                    r_cnt     <= '0;
                    r_sum     <= '0;
                    r_wait    <= 1'b1;
                    r_q_valid <= 1'b1;
                    r_q.n     <= n_len;
                    r_q.ovf   <= n_cnt > CNT_W'(MAX_SAMPLES);
                    r_q.sum   <= n_sum;
                    r_q.gate  <= (n_len < CNT_W'(gate_c)) ? GATE_W'(n_len) : gate_c;
                end else begin
                    r_cnt <= n_cnt;
                    r_sum <= n_sum;
                end
            end
        end
    end

endmodule

`default_nettype wire

@@ design/psca_back.sv @@
// ----------------------------------------------------------------------------
// psca_back
// Evaluator: baseline division, optional CR-RC shaping pass into the shaped
// store, peak choice, windowed charge sum and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module psca_back (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    input  psca_pkg::t_cfg                    i_cfg,
    input  wire                               i_job_valid,
    output logic                              o_job_pop,
    input  psca_pkg::t_job                    i_job,
    output logic [psca_pkg::ADDR_W-1:0]       o_rd_addr,
    input  wire  signed [psca_pkg::SMP_W-1:0] i_rd_data,
    output logic                              o_release,
    output logic                              o_out_valid,
    input  wire                               i_out_ready,
    output logic signed [psca_pkg::Q_W-1:0]   o_amplitude,
    output logic signed [psca_pkg::CHG_W-1:0] o_charge,
    output logic [psca_pkg::ADDR_W-1:0]       o_peak_position,
    output logic                              o_negative_pulse,
    output logic                              o_overflow
);
    import psca_pkg::*;

    localparam logic signed [Q_W-1:0]   Q_MAX = {1'b0, {(Q_W-1){1'b1}}};
    localparam logic signed [Q_W-1:0]   Q_MIN = {1'b1, {(Q_W-1){1'b0}}};
    localparam logic signed [CHG_W-1:0] C_MAX = {1'b0, {(CHG_W-1){1'b1}}};
    localparam logic signed [CHG_W-1:0] C_MIN = {1'b1, {(CHG_W-1){1'b0}}};

    t_state r_state, n_state;

    logic signed [Q_W-1:0]   r_shaped [MAX_SAMPLES];
    logic signed [Q_W-1:0]   r_sh_rd;

    t_job                    r_job;
    logic [DIV_W-1:0]        r_div;
    logic [GATE_W-1:0]       r_rem;
    logic [DCNT_W-1:0]       r_dcnt;
    logic [ADDR_W-1:0]       r_idx;
    logic [ADDR_W-1:0]       r_last_idx;
    logic [ADDR_W-1:0]       r_end;
    logic [LP_W-1:0]         r_k;
    logic signed [Q_W-1:0]   r_v;
    logic signed [Q_W-1:0]   r_hp_in, r_hp_out;
    logic signed [Q_W-1:0]   r_lp [LP_STAGES];
    logic signed [Q_W-1:0]   r_max, r_min, r_amp;
    logic [ADDR_W-1:0]       r_pmax, r_pmin, r_peak;
    logic                    r_neg;
    logic                    r_ov;
    logic signed [CHG_W-1:0] r_acc;

    // Divider step signals.
    logic [GATE_W:0]         rem_sh;
    logic                    div_ge;
    logic [SUM_W-1:0]        mag;

    // Shaping datapath signals.
    logic signed [BASE_W:0]  base;
    logic signed [BASE_W:0]  x_base;
    logic signed [42:0]      d;
    logic signed [59:0]      prod;
    logic signed [59:0]      prod_r;
    logic signed [44:0]      y_sum;
    logic signed [Q_W-1:0]   y_sat;
    logic                    y_ovf;

    // Peak and window signals.
    logic signed [Q_W:0]     amax, amin, neg_min;
    logic [CNT_W-1:0]        n_q;
    logic [GATE_W-1:0]       w;
    logic [CNT_W-1:0]        end_full;

    // Charge step signals.
    logic signed [Q_W:0]     term;
    logic signed [CHG_W:0]   c_sum;

    logic                    out_free;

    assign out_free = ~o_out_valid | i_out_ready;

    // Restoring division, one quotient bit per cycle.
    assign rem_sh = {r_rem, r_div[DIV_W-1]};
    assign div_ge = rem_sh >= {1'b0, r_job.gate};
    assign mag    = i_job.sum[SUM_W-1] ? SUM_W'(-i_job.sum) : SUM_W'(i_job.sum);

    // Shared coefficient multiplier for the CR and RC stages.
    always_comb begin
        base   = r_job.sum[SUM_W-1] ? -$signed({1'b0, r_div[BASE_W-1:0]})
                                    : $signed({1'b0, r_div[BASE_W-1:0]});
        x_base = $signed({i_rd_data, 16'b0, 2'b00}) >>> 2;
        x_base = x_base - base;
        if (r_state == ST_HP) begin
            d = 43'(r_hp_out) + 43'(r_v) - 43'(r_hp_in);
        end else begin
            d = 43'(r_v) - 43'(r_lp[r_k]);
        end
        prod   = $signed({1'b0, (r_state == ST_HP) ? i_cfg.highpass_coef
                                                   : i_cfg.lowpass_coef}) * d;
        prod_r = prod + 60'sd32768;
        if (r_state == ST_HP) begin
            y_sum = 45'($signed(prod_r[59:16]));
        end else begin
            y_sum = 45'($signed(prod_r[59:16])) + 45'(r_lp[r_k]);
        end
        y_ovf = 1'b0;
        if (y_sum > 45'(Q_MAX)) begin
            y_sat = Q_MAX;
            y_ovf = 1'b1;
        end else if (y_sum < 45'(Q_MIN)) begin
            y_sat = Q_MIN;
            y_ovf = 1'b1;
        end else begin
            y_sat = Q_W'(y_sum);
        end
    end

    // Peak choice and window bounds.
    always_comb begin
        amax     = r_max[Q_W-1] ? -(41'(r_max)) : 41'(r_max);
        amin     = r_min[Q_W-1] ? -(41'(r_min)) : 41'(r_min);
        neg_min  = -(41'(r_min));
        n_q      = r_job.n >> 2;
        w        = GATE_W'(i_cfg.window_half);
        if (i_cfg.window_quarter_limit && (CNT_W'(w) > n_q)) begin
            w = GATE_W'(n_q);
        end
        end_full = CNT_W'(r_peak) + CNT_W'(w);
    end

    // Charge accumulation with saturation.
    always_comb begin
        term  = r_neg ? -(41'(r_sh_rd)) : 41'(r_sh_rd);
        c_sum = 52'(r_acc) + 52'(term);
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: if (i_job_valid) n_state = ST_DIV;
            ST_DIV:  if (r_dcnt == DCNT_W'(DIV_W - 1)) n_state = ST_RD;
            ST_RD:   n_state = ST_LOAD;
            ST_LOAD: n_state = i_cfg.shaping_en ? ST_HP : ST_WR;
            ST_HP:   n_state = ST_LP;
            ST_LP:   if (r_k == LP_W'(LP_STAGES - 1)) n_state = ST_WR;
            ST_WR:   n_state = (r_idx == r_last_idx) ? ST_PEAK : ST_RD;
            ST_PEAK: n_state = ST_WIN;
            ST_WIN:  n_state = ST_IRD;
            ST_IRD:  n_state = ST_IACC;
            ST_IACC: n_state = (r_idx == r_end) ? ST_FIN : ST_IRD;
            ST_FIN:  if (out_free) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    // Control outputs.
    always_comb begin
        o_job_pop = 1'b0;
        o_release = 1'b0;
        o_rd_addr = r_idx;
        case (r_state)
            ST_IDLE: o_job_pop = i_job_valid;
            ST_WR:   o_release = r_idx == r_last_idx;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Shaped store, write and registered read.
    always_ff @(posedge i_clk) begin
        if (r_state == ST_WR) begin
            r_shaped[r_idx] <= r_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sh_rd <= r_shaped[r_idx];
    end

    // Evaluation datapath.
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                r_job      <= i_job;
                r_div      <= DIV_W'({mag, 16'b0}) + DIV_W'(i_job.gate >> 1);
                r_rem      <= '0;
                r_dcnt     <= '0;
                r_idx      <= '0;
                r_last_idx <= ADDR_W'(i_job.n - CNT_W'(1));
                r_ov       <= i_job.ovf;
                r_hp_in    <= '0;
                r_hp_out   <= '0;
                for (int i = 0; i < LP_STAGES; i++) begin
                    r_lp[i] <= '0;
                end
            end
            ST_DIV: begin
                r_div  <= {r_div[DIV_W-2:0], div_ge};
                r_rem  <= div_ge ? GATE_W'(rem_sh - {1'b0, r_job.gate})
                                 : GATE_W'(rem_sh);
                r_dcnt <= r_dcnt + DCNT_W'(1);
            end
            ST_LOAD: begin
                r_v <= Q_W'(x_base);
            end
            ST_HP: begin
                r_v      <= y_sat;
                r_hp_in  <= r_v;
                r_hp_out <= y_sat;
                r_k      <= '0;
                r_ov     <= r_ov | y_ovf;
            end
            ST_LP: begin
                r_v       <= y_sat;
                r_lp[r_k] <= y_sat;
                r_k       <= r_k + LP_W'(1);
                r_ov      <= r_ov | y_ovf;
            end
            ST_WR: begin
                if ((r_idx == '0) || (r_v > r_max)) begin
                    r_max  <= r_v;
                    r_pmax <= r_idx;
                end
                if ((r_idx == '0) || (r_v < r_min)) begin
                    r_min  <= r_v;
                    r_pmin <= r_idx;
                end
                if (r_idx != r_last_idx) begin
                    r_idx <= r_idx + ADDR_W'(1);
                end
            end
            ST_PEAK: begin
                r_neg <= i_cfg.polarity_auto & (amin > amax);
                if (i_cfg.polarity_auto && (amin > amax)) begin
                    r_peak <= r_pmin;
                    if (neg_min > 41'(Q_MAX)) begin
                        r_amp <= Q_MAX;
                        r_ov  <= 1'b1;
                    end else begin
                        r_amp <= Q_W'(neg_min);
                    end
                end else begin
                    r_peak <= r_pmax;
                    r_amp  <= r_max;
                end
            end
            ST_WIN: begin
                r_idx <= (r_peak > ADDR_W'(w)) ? r_peak - ADDR_W'(w) : '0;
                r_end <= (end_full > CNT_W'(r_last_idx)) ? r_last_idx
                                                         : ADDR_W'(end_full);
                r_acc <= '0;
            end
            ST_IACC: begin
                if (c_sum > 52'(C_MAX)) begin
                    r_acc <= C_MAX;
                    r_ov  <= 1'b1;
                end else if (c_sum < 52'(C_MIN)) begin
                    r_acc <= C_MIN;
                    r_ov  <= 1'b1;
                end else begin
                    r_acc <= CHG_W'(c_sum);
                end
                if (r_idx != r_end) begin
                    r_idx <= r_idx + ADDR_W'(1);
                end
            end
            default: ;
        endcase
    end

    // Result register; a finished result waits here to be taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (r_state == ST_FIN && out_free) begin
            o_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            o_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_FIN && out_free) begin
            o_amplitude      <= r_amp;
            o_charge         <= r_acc;
            o_peak_position  <= r_peak;
            o_negative_pulse <= r_neg;
            o_overflow       <= r_ov;
        end
    end

endmodule

`default_nettype wire

@@ design/pulse_shaping_charge_analyzer_unit.sv @@
// ----------------------------------------------------------------------------
// pulse_shaping_charge_analyzer_unit
// Top level: configuration registers, waveform loader and evaluator.
// ----------------------------------------------------------------------------
// Samples are taken one per cycle, while o_in_ready is high, into a
// 4096-entry raw store; the beat marked last closes the waveform and one
// result follows it. Evaluation of a waveform then runs the baseline
// division (one quotient bit a cycle), the shaping pass over the stored
// samples with the filter on (one shared coefficient multiplier serves
// the CR stage and the four RC stages in turn) or with it off, and then
// the integration window over the shaped store, plus bookkeeping. The
// next waveform may start loading as soon as the shaping pass has finished
// with the raw store; a finished result is held in an output register until
// it is taken. Configuration must be written only while the block is idle.
`default_nettype none

module pulse_shaping_charge_analyzer_unit (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 i_in_valid,
    output logic                                o_in_ready,
    input  wire  signed [psca_pkg::SMP_W-1:0]   i_sample,
    input  wire                                 i_last,
    output logic                                o_out_valid,
    input  wire                                 i_out_ready,
    output logic signed [psca_pkg::Q_W-1:0]     o_amplitude,
    output logic signed [psca_pkg::CHG_W-1:0]   o_charge,
    output logic [psca_pkg::ADDR_W-1:0]         o_peak_position,
    output logic                                o_negative_pulse,
    output logic                                o_overflow,
    input  wire                                 i_cfg_we,
    input  wire  [psca_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  wire  [psca_pkg::COEF_W-1:0]         i_cfg_data
);
    import psca_pkg::*;

    t_cfg                    r_cfg;
    t_job                    job;
    logic                    job_valid, job_pop, release_raw;
    logic [ADDR_W-1:0]       rd_addr;
    logic signed [SMP_W-1:0] rd_data;

    // Configuration register bank.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_SHAPING_EN:    r_cfg.shaping_en           <= i_cfg_data[0];
                REG_LOWPASS_COEF:  r_cfg.lowpass_coef         <= i_cfg_data;
                REG_HIGHPASS_COEF: r_cfg.highpass_coef        <= i_cfg_data;
                REG_BASELINE_GATE: r_cfg.baseline_gate        <= i_cfg_data[GATE_W-1:0];
                REG_WINDOW_HALF:   r_cfg.window_half          <= i_cfg_data[WIN_W-1:0];
                REG_WINDOW_QLIM:   r_cfg.window_quarter_limit <= i_cfg_data[0];
                REG_POLARITY_AUTO: r_cfg.polarity_auto        <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    psca_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_sample    (i_sample),
        .i_last      (i_last),
        .i_gate      (r_cfg.baseline_gate),
        .i_rd_addr   (rd_addr),
        .o_rd_data   (rd_data),
        .i_release   (release_raw),
        .o_job_valid (job_valid),
        .i_job_pop   (job_pop),
        .o_job       (job)
    );

    psca_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg            (r_cfg),
        .i_job_valid      (job_valid),
        .o_job_pop        (job_pop),
        .i_job            (job),
        .o_rd_addr        (rd_addr),
        .i_rd_data        (rd_data),
        .o_release        (release_raw),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_amplitude      (o_amplitude),
        .o_charge         (o_charge),
        .o_peak_position  (o_peak_position),
        .o_negative_pulse (o_negative_pulse),
        .o_overflow       (o_overflow)
    );

endmodule

`default_nettype wire
